[design/csl_pkg.sv]
// Package for the cache set with LRU order and MESI line states.
// Holds sizes, line state and mode codes, cell commands and the chain types.
// Used by csl_cell and cache_set_lru_coherence.
`default_nettype none
package csl_pkg;

    localparam int WAYS      = 8;
    localparam int TAG_BITS  = 20;
    localparam int MODE_BITS = 3;
    localparam int RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_BITS  = $clog2(WAYS + 1);
    localparam int IN_W      = ((MODE_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int OUT_USED  = 6 + TAG_BITS;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_INV = 2'd0,
        ST_SHR = 2'd1,
        ST_EXC = 2'd2,
        ST_MOD = 2'd3
    } t_line;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_READ  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_SNOOP = 3'd2,
        MODE_INVAL = 3'd3,
        MODE_RESET = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        FETCH_NONE = 2'd0,
        FETCH_READ = 2'd1,
        FETCH_OWN  = 2'd2
    } t_fetch;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PROMOTE,
        CELL_DROP,
        CELL_INSERT,
        CELL_KILL,
        CELL_CLEAR
    } t_cell_op;

    typedef enum logic {
        FSM_IDLE,
        FSM_EXEC
    } t_fsm;

    typedef struct packed {
        t_cell_op              op;
        logic [TAG_BITS-1:0]   tag;
        logic [RANK_BITS-1:0]  ref_rank;
        t_line                 new_state;
        logic                  full;
        logic [RANK_BITS-1:0]  victim_rank;
    } t_cell_cmd;

    typedef struct packed {
        logic ins_taken;
        logic mod_seen;
        logic mod_two;
    } t_chain;

    typedef struct packed {
        logic                  valid;
        logic                  match;
        logic                  victim;
        logic                  mod_first;
        t_line                 state;
        logic [TAG_BITS-1:0]   tag;
        logic [RANK_BITS-1:0]  rank;
    } t_cell_stat;

endpackage
`default_nettype wire

[design/cache_set_lru_coherence.sv]
// An item is taken when idle; its result is registered in the execute state once
// the output is free. No new item is taken until the last one has executed.
// Set reset gives a result per modified line (one if none), one per cycle when the
// output is free. A stalled output holds the set until the result is taken.
// i_rst_n (synchronous, active low) invalidates all ways and zeroes the LRU ranks.
// Top level: chain of csl_cell ways plus request control; uses csl_pkg.
`default_nettype none
module cache_set_lru_coherence (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // mode[2:0], tag[22:3], zero fill
    input  wire  [csl_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire                        i_m_axis_tready,
    // hit[0], fetch[2:1], write_through[3], writeback[4], writeback_tag[24:5],
    // return_data[25], zero fill
    output logic [csl_pkg::OUT_W-1:0]  o_m_axis_tdata,
    output logic                       o_m_axis_tlast
);

    localparam int W  = csl_pkg::WAYS;
    localparam int TB = csl_pkg::TAG_BITS;
    localparam int MB = csl_pkg::MODE_BITS;

    csl_pkg::t_fsm                r_fsm, n_fsm;
    logic [MB-1:0]                r_mode;
    logic [TB-1:0]                r_tag;
    logic [csl_pkg::CNT_BITS-1:0] r_count, n_count;

    logic                         r_out_valid;
    logic                         r_hit, n_hit;
    logic [1:0]                   r_fetch, n_fetch;
    logic                         r_wt, n_wt;
    logic                         r_wb, n_wb;
    logic [TB-1:0]                r_wbtag, n_wbtag;
    logic                         r_rd, n_rd;
    logic                         r_last, n_last;
    logic                         out_load;

    csl_pkg::t_cell_cmd           cmd;
    csl_pkg::t_chain              chain [W+1];
    csl_pkg::t_cell_stat          stat  [W];

    logic                         hit, vic_mod, any_mod, full, out_free;
    logic [1:0]                   hit_st_bits;
    csl_pkg::t_line               hit_state;
    logic [csl_pkg::RANK_BITS-1:0] hit_rank;
    logic [TB-1:0]                hit_tag, vic_tag, mod_tag;
    logic [W-1:0]                 valid_vec, match_vec;

    assign chain[0] = '{ins_taken: 1'b0, mod_seen: 1'b0, mod_two: 1'b0};

    for (genvar g = 0; g < W; g++) begin : g_way
        csl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .o_stat  (stat[g])
        );
    end

    always_comb begin
        hit         = 1'b0;
        vic_mod     = 1'b0;
        any_mod     = 1'b0;
        hit_st_bits = '0;
        hit_rank    = '0;
        hit_tag     = '0;
        vic_tag     = '0;
        mod_tag     = '0;
        for (int i = 0; i < W; i++) begin
            valid_vec[i] = stat[i].valid;
            match_vec[i] = stat[i].match;
            if (stat[i].match) begin
                hit         = 1'b1;
                hit_st_bits = hit_st_bits | stat[i].state;
                hit_rank    = hit_rank | stat[i].rank;
                hit_tag     = hit_tag | stat[i].tag;
            end
            if (stat[i].victim && (stat[i].state == csl_pkg::ST_MOD)) begin
                vic_mod = 1'b1;
                vic_tag = vic_tag | stat[i].tag;
            end
            if (stat[i].mod_first) begin
                any_mod = 1'b1;
                mod_tag = mod_tag | stat[i].tag;
            end
        end
        hit_state = csl_pkg::t_line'(hit_st_bits);
    end

    assign full     = (r_count == csl_pkg::CNT_BITS'(W));
    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_fsm           = r_fsm;
        n_count         = r_count;
        o_s_axis_tready = (r_fsm == csl_pkg::FSM_IDLE);
        out_load        = 1'b0;
        n_hit           = 1'b0;
        n_fetch         = csl_pkg::FETCH_NONE;
        n_wt            = 1'b0;
        n_wb            = 1'b0;
        n_wbtag         = '0;
        n_rd            = 1'b0;
        n_last          = 1'b1;
        cmd.op          = csl_pkg::CELL_HOLD;
        cmd.tag         = r_tag;
        cmd.ref_rank    = hit_rank;
        cmd.new_state   = hit_state;
        cmd.full        = full;
        cmd.victim_rank = csl_pkg::RANK_BITS'(r_count - 1'b1);

        unique case (r_fsm)
            csl_pkg::FSM_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_fsm = csl_pkg::FSM_EXEC;
                end
            end
            csl_pkg::FSM_EXEC: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_fsm    = csl_pkg::FSM_IDLE;
                    unique case (r_mode) inside
                        csl_pkg::MODE_READ, csl_pkg::MODE_WRITE: begin
                            n_hit = hit;
                            if (hit) begin
                                cmd.op = csl_pkg::CELL_PROMOTE;
                                if (r_mode == csl_pkg::MODE_WRITE) begin
                                    if (hit_state == csl_pkg::ST_EXC ||
                                        hit_state == csl_pkg::ST_MOD) begin
                                        cmd.new_state = csl_pkg::ST_MOD;
                                    end else begin
                                        cmd.new_state = csl_pkg::ST_EXC;
                                        n_fetch       = csl_pkg::FETCH_READ;
                                    end
                                end
                            end else begin
                                cmd.op  = csl_pkg::CELL_INSERT;
                                n_wb    = full && vic_mod;
                                n_wbtag = (full && vic_mod) ? vic_tag : '0;
                                if (!full) begin
                                    n_count = r_count + 1'b1;
                                end
                                if (r_mode == csl_pkg::MODE_WRITE) begin
                                    cmd.new_state = csl_pkg::ST_EXC;
                                    n_fetch       = csl_pkg::FETCH_OWN;
                                    n_wt          = 1'b1;
                                end else begin
                                    cmd.new_state = csl_pkg::ST_SHR;
                                    n_fetch       = csl_pkg::FETCH_READ;
                                end
                            end
                        end
                        csl_pkg::MODE_SNOOP: begin
                            n_hit = hit;
                            if (hit) begin
                                cmd.op        = csl_pkg::CELL_PROMOTE;
                                cmd.new_state = csl_pkg::ST_SHR;
                                n_rd = (hit_state == csl_pkg::ST_MOD) ||
                                       (hit_state == csl_pkg::ST_EXC);
                            end
                        end
                        csl_pkg::MODE_INVAL: begin
                            n_hit = hit;
                            if (hit) begin
                                cmd.op  = csl_pkg::CELL_DROP;
                                n_count = r_count - 1'b1;
                                n_wb    = (hit_state == csl_pkg::ST_MOD);
                                n_wbtag = (hit_state == csl_pkg::ST_MOD) ? hit_tag : '0;
                            end
                        end
                        csl_pkg::MODE_RESET: begin
                            if (any_mod) begin
                                n_wb    = 1'b1;
                                n_wbtag = mod_tag;
                                n_last  = !chain[W].mod_two;
                            end
                            if (any_mod && chain[W].mod_two) begin
                                cmd.op  = csl_pkg::CELL_KILL;
                                n_count = r_count - 1'b1;
                                n_fsm   = csl_pkg::FSM_EXEC;
                            end else begin
                                cmd.op  = csl_pkg::CELL_CLEAR;
                                n_count = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_fsm = csl_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= csl_pkg::FSM_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm   <= n_fsm;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_mode <= i_s_axis_tdata[MB-1:0];
            r_tag  <= i_s_axis_tdata[MB+TB-1:MB];
        end
        if (out_load) begin
            r_hit   <= n_hit;
            r_fetch <= n_fetch;
            r_wt    <= n_wt;
            r_wb    <= n_wb;
            r_wbtag <= n_wbtag;
            r_rd    <= n_rd;
            r_last  <= n_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tdata  = {{(csl_pkg::OUT_W - csl_pkg::OUT_USED){1'b0}},
                              r_rd, r_wbtag, r_wb, r_wt, r_fetch, r_hit};

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= csl_pkg::CNT_BITS'(W))
        else $error("valid count above way count");

    a_count_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_count))
        else $error("valid count disagrees with valid ways");

    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("tag matches more than one valid way");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> (r_fsm == csl_pkg::FSM_EXEC))
        else $error("accepted item not executed");

    a_own_wt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_fetch == csl_pkg::FETCH_OWN)) |-> (r_wt && !r_hit))
        else $error("ownership fetch without write through");
`endif

endmodule
`default_nettype wire

[design/csl_cell.sv]
// One way of the set: tag, line state and LRU rank.
// Passes the free-slot and modified-line chain to the next way; uses csl_pkg.
`default_nettype none
module csl_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  csl_pkg::t_cell_cmd  i_cmd,
    input  csl_pkg::t_chain     i_chain,
    output csl_pkg::t_chain     o_chain,
    output csl_pkg::t_cell_stat o_stat
);

    logic [csl_pkg::TAG_BITS-1:0]  r_tag, n_tag;
    csl_pkg::t_line                r_state, n_state;
    logic [csl_pkg::RANK_BITS-1:0] r_rank, n_rank;

    logic valid, match, victim, free_cand, ins_sel, is_mod, mod_first;

    always_comb begin
        valid     = (r_state != csl_pkg::ST_INV);
        match     = valid && (r_tag == i_cmd.tag);
        victim    = valid && i_cmd.full && (r_rank == i_cmd.victim_rank);
        free_cand = !valid || victim;
        ins_sel   = free_cand && !i_chain.ins_taken;
        is_mod    = (r_state == csl_pkg::ST_MOD);
        mod_first = is_mod && !i_chain.mod_seen;

        o_chain.ins_taken = i_chain.ins_taken | free_cand;
        o_chain.mod_seen  = i_chain.mod_seen | is_mod;
        o_chain.mod_two   = i_chain.mod_two | (is_mod & i_chain.mod_seen);

        o_stat.valid     = valid;
        o_stat.match     = match;
        o_stat.victim    = victim;
        o_stat.mod_first = mod_first;
        o_stat.state     = r_state;
        o_stat.tag       = r_tag;
        o_stat.rank      = r_rank;
    end

    always_comb begin
        n_tag   = r_tag;
        n_state = r_state;
        n_rank  = r_rank;
        case (i_cmd.op)
            csl_pkg::CELL_PROMOTE: begin
                if (match) begin
                    n_state = i_cmd.new_state;
                    n_rank  = '0;
                end else if (valid && (r_rank < i_cmd.ref_rank)) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            csl_pkg::CELL_DROP: begin
                if (match) begin
                    n_state = csl_pkg::ST_INV;
                    n_rank  = '0;
                end else if (valid && (r_rank > i_cmd.ref_rank)) begin
                    n_rank = r_rank - 1'b1;
                end
            end
            csl_pkg::CELL_INSERT: begin
                if (ins_sel) begin
                    n_tag   = i_cmd.tag;
                    n_state = i_cmd.new_state;
                    n_rank  = '0;
                end else if (valid) begin
                    n_rank = r_rank + 1'b1;
                end
            end
            csl_pkg::CELL_KILL: begin
                if (mod_first) begin
                    n_state = csl_pkg::ST_INV;
                    n_rank  = '0;
                end
            end
            csl_pkg::CELL_CLEAR: begin
                n_state = csl_pkg::ST_INV;
                n_rank  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csl_pkg::ST_INV;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag <= n_tag;
    end

endmodule
`default_nettype wire

[bench/cache_set_lru_coherence_tb.sv]
// Testbench for cache_set_lru_coherence: sends read, write, snoop, invalidate and set reset
// requests and checks each result against a cycle-free model of tags, line states and LRU order.
// Depends on csl_pkg and the cache_set_lru_coherence top level.
`timescale 1ns / 1ps
module cache_set_lru_coherence_tb;
    import csl_pkg::*;

    localparam logic [MODE_BITS-1:0] MODE_UNDEF_LO = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_UNDEF_HI = 3'd7;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 12;

    typedef struct packed {
        logic                hit;
        t_fetch              fetch;
        logic                wt;
        logic                wb;
        logic [TAG_BITS-1:0] wb_tag;
        logic                rd;
        logic                last;
    } t_reply;

    logic                i_clk;
    logic                rst_n   = 1'b0;
    logic                s_valid = 1'b0;
    logic [IN_W-1:0]     s_data  = '0;
    logic                m_ready = 1'b0;
    wire                 s_ready;
    wire                 m_valid;
    wire  [OUT_W-1:0]    m_data;
    wire                 m_last;

    logic [TAG_BITS-1:0]  line_tag  [WAYS];
    t_line                line_st   [WAYS];
    logic [RANK_BITS-1:0] line_rank [WAYS];
    int                   lines_valid;
    t_reply               replies_due [$];
    logic [TAG_BITS-1:0]  tag_pool [POOL_SIZE];

    logic send_gaps   = 1'b0;
    logic recv_stalls = 1'b0;
    logic hold_req    = 1'b0;
    int   mismatches  = 0;
    int   items_sent  = 0;
    int   results_checked = 0;
    int   writebacks_seen = 0;
    int   idle_cycles = 0;

    cache_set_lru_coherence i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_line(logic [TAG_BITS-1:0] t);
        for (int i = 0; i < WAYS; i++)
            if (line_st[i] != ST_INV && line_tag[i] == t)
                return i;
        return -1;
    endfunction

    function automatic void promote_line(int w);
        logic [RANK_BITS-1:0] r;
        r = line_rank[w];
        for (int i = 0; i < WAYS; i++)
            if (line_st[i] != ST_INV && line_rank[i] < r)
                line_rank[i]++;
        line_rank[w] = '0;
    endfunction

    function automatic void drop_line(int w);
        logic [RANK_BITS-1:0] r;
        r = line_rank[w];
        for (int i = 0; i < WAYS; i++)
            if (i != w && line_st[i] != ST_INV && line_rank[i] > r)
                line_rank[i]--;
        line_st[w]   = ST_INV;
        line_rank[w] = '0;
        if (lines_valid > 0)
            lines_valid--;
    endfunction

    function automatic void evict_lru(output logic wb, output logic [TAG_BITS-1:0] wb_tag);
        wb     = 1'b0;
        wb_tag = '0;
        if (lines_valid < WAYS)
            return;
        for (int i = 0; i < WAYS; i++) begin
            if (line_st[i] != ST_INV && int'(line_rank[i]) == lines_valid - 1) begin
                if (line_st[i] == ST_MOD) begin
                    wb     = 1'b1;
                    wb_tag = line_tag[i];
                end
                drop_line(i);
                return;
            end
        end
    endfunction

    function automatic void install_line(logic [TAG_BITS-1:0] t, t_line st);
        int w;
        w = -1;
        for (int i = 0; i < WAYS; i++)
            if (w < 0 && line_st[i] == ST_INV)
                w = i;
        if (w < 0)
            return;
        for (int i = 0; i < WAYS; i++)
            if (line_st[i] != ST_INV)
                line_rank[i]++;
        line_tag[w]  = t;
        line_st[w]   = st;
        line_rank[w] = '0;
        lines_valid++;
    endfunction

    function automatic void owe_reply(logic hit, t_fetch f, logic wt, logic wb,
                                      logic [TAG_BITS-1:0] wb_tag, logic rd, logic last);
        t_reply r;
        r.hit    = hit;
        r.fetch  = f;
        r.wt     = wt;
        r.wb     = wb;
        r.wb_tag = wb_tag;
        r.rd     = rd;
        r.last   = last;
        replies_due.push_back(r);
    endfunction

    function automatic void apply_request(logic [MODE_BITS-1:0] m, logic [TAG_BITS-1:0] t);
        int                  w;
        int                  n_mod;
        int                  k;
        logic                wb;
        logic [TAG_BITS-1:0] wb_tag;
        t_fetch              f;
        logic                rd;
        w = find_line(t);
        case (m)
            MODE_READ: begin
                if (w >= 0) begin
                    promote_line(w);
                    owe_reply(1'b1, FETCH_NONE, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    evict_lru(wb, wb_tag);
                    install_line(t, ST_SHR);
                    owe_reply(1'b0, FETCH_READ, 1'b0, wb, wb_tag, 1'b0, 1'b1);
                end
            end
            MODE_WRITE: begin
                if (w >= 0) begin
                    f = FETCH_NONE;
                    if (line_st[w] == ST_EXC) begin
                        line_st[w] = ST_MOD;
                    end else if (line_st[w] != ST_MOD) begin
                        line_st[w] = ST_EXC;
                        f = FETCH_READ;
                    end
                    promote_line(w);
                    owe_reply(1'b1, f, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end else begin
                    evict_lru(wb, wb_tag);
                    install_line(t, ST_EXC);
                    owe_reply(1'b0, FETCH_OWN, 1'b1, wb, wb_tag, 1'b0, 1'b1);
                end
            end
            MODE_SNOOP: begin
                if (w >= 0) begin
                    rd = (line_st[w] == ST_MOD || line_st[w] == ST_EXC);
                    line_st[w] = ST_SHR;
                    promote_line(w);
                    owe_reply(1'b1, FETCH_NONE, 1'b0, 1'b0, '0, rd, 1'b1);
                end else begin
                    owe_reply(1'b0, FETCH_NONE, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            MODE_INVAL: begin
                if (w >= 0) begin
                    wb     = (line_st[w] == ST_MOD);
                    wb_tag = wb ? line_tag[w] : '0;
                    drop_line(w);
                    owe_reply(1'b1, FETCH_NONE, 1'b0, wb, wb_tag, 1'b0, 1'b1);
                end else begin
                    owe_reply(1'b0, FETCH_NONE, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                end
            end
            MODE_RESET: begin
                n_mod = 0;
                k     = 0;
                for (int i = 0; i < WAYS; i++)
                    if (line_st[i] == ST_MOD)
                        n_mod++;
                for (int i = 0; i < WAYS; i++) begin
                    if (line_st[i] == ST_MOD) begin
                        k++;
                        owe_reply(1'b0, FETCH_NONE, 1'b0, 1'b1, line_tag[i], 1'b0, k == n_mod);
                    end
                    line_st[i]   = ST_INV;
                    line_rank[i] = '0;
                end
                lines_valid = 0;
                if (n_mod == 0)
                    owe_reply(1'b0, FETCH_NONE, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            end
            default: begin
                owe_reply(1'b0, FETCH_NONE, 1'b0, 1'b0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [MODE_BITS-1:0] pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return MODE_READ;
        if (r < 70)
            return MODE_WRITE;
        if (r < 85)
            return MODE_SNOOP;
        if (r < 95)
            return MODE_INVAL;
        if (r < 98)
            return MODE_RESET;
        return MODE_BITS'($urandom_range(MODE_UNDEF_LO, MODE_UNDEF_HI));
    endfunction

    function automatic logic [TAG_BITS-1:0] pick_tag();
        if ($urandom_range(0, 9) == 0)
            return TAG_BITS'($urandom);
        return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    task automatic send_item(input logic [MODE_BITS-1:0] m, input logic [TAG_BITS-1:0] t);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= IN_W'({t, m});
        do @(posedge i_clk); while (!s_ready);
        apply_request(m, t);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (replies_due.size() != 0 || hold_req)
            @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(MODE_RESET, '0);
        send_item(MODE_READ, '0);
        send_item(MODE_READ, '1);
        send_item(MODE_READ, '0);
        send_item(MODE_WRITE, '1);
        send_item(MODE_WRITE, '1);
        send_item(MODE_WRITE, '1);
        send_item(MODE_WRITE, 20'h12345);
        send_item(MODE_SNOOP, '1);
        send_item(MODE_SNOOP, 20'h12345);
        send_item(MODE_SNOOP, 20'h12345);
        send_item(MODE_SNOOP, 20'h55555);
        send_item(MODE_INVAL, '0);
        send_item(MODE_INVAL, '0);
        send_item(MODE_UNDEF_LO, 20'hAAAAA);
        send_item(MODE_UNDEF_HI, 20'h55555);
        for (int i = 0; i < WAYS; i++)
            send_item(MODE_WRITE, TAG_BITS'(20'h00100 + i));
        send_item(MODE_WRITE, 20'h00101);
        send_item(MODE_INVAL, 20'h00101);
        send_item(MODE_WRITE, 20'h00102);
        send_item(MODE_RESET, '1);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            tag_pool[i] = TAG_BITS'($urandom);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        for (int n = 0; n < 220; n++)
            send_item(pick_mode(), pick_tag());
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_gaps = 1'b0;
        hold_req  = 1'b1;
        for (int n = 0; n < 40; n++)
            send_item(pick_mode(), pick_tag());
        wait_drained();
    endtask

    task automatic test_full_rate();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        for (int n = 0; n < 50; n++)
            send_item(pick_mode(), pick_tag());
        s_valid <= 1'b0;
    endtask

    initial begin
        for (int i = 0; i < WAYS; i++) begin
            line_tag[i]  = '0;
            line_st[i]   = ST_INV;
            line_rank[i] = '0;
        end
        lines_valid = 0;
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic();
        test_backpressure();
        test_full_rate();
        while (replies_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("sent %0d requests of all modes; checked %0d results, %0d with writeback",
                 items_sent, results_checked, writebacks_seen);
        $display("phases: directed, random with idling, long output stall, full rate");
        if (mismatches == 0 && replies_due.size() == 0)
            $display("cache_set_lru_coherence_tb: done, clean");
        else
            $display("cache_set_lru_coherence_tb: done, errors");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (recv_stalls && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_reply want;
        if (rst_n && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                $error("result with no request pending: tdata 0x%0h, tlast %0b", m_data, m_last);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_data[0]));
                check_field("fetch", 32'(want.fetch), 32'(m_data[2:1]));
                check_field("write_through", 32'(want.wt), 32'(m_data[3]));
                check_field("writeback", 32'(want.wb), 32'(m_data[4]));
                check_field("writeback_tag", 32'(want.wb_tag), 32'(m_data[24:5]));
                check_field("return_data", 32'(want.rd), 32'(m_data[25]));
                check_field("last", 32'(want.last), 32'(m_last));
                results_checked++;
                if (m_data[4])
                    writebacks_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("cache_set_lru_coherence_tb: done, errors");
            $finish;
        end
    end

endmodule
